// ----- sv/cee_pkg.sv -----
package cee_pkg;

  // Field widths of the request and result channels.
  localparam int OP_W       = 4;
  localparam int IMM_W      = 64;
  localparam int IDX_W      = 32;
  localparam int VALUE_W    = 64;
  localparam int STATUS_W   = 3;

  // Packing of in_tdata: opcode, immediate, item_index from the lowest bit up.
  localparam int IN_OP_LSB  = 0;
  localparam int IN_IMM_LSB = IN_OP_LSB + OP_W;
  localparam int IN_IDX_LSB = IN_IMM_LSB + IMM_W;
  localparam int IN_TDATA_W = ((IN_IDX_LSB + IDX_W + 7) / 8) * 8;

  // Packing of out_tdata: value, status from the lowest bit up.
  localparam int OUT_VALUE_LSB  = 0;
  localparam int OUT_STATUS_LSB = OUT_VALUE_LSB + VALUE_W;
  localparam int OUT_TDATA_W    = ((OUT_STATUS_LSB + STATUS_W + 7) / 8) * 8;

  // Configuration registers.
  localparam int GCOUNT_W   = 7;
  localparam int FCOUNT_W   = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_COUNT = 1'b1;

  // Instruction opcodes; codes 14 and 15 are not defined.
  typedef enum logic [OP_W-1:0] {
    OP_I32_CONST  = 4'd0,
    OP_I64_CONST  = 4'd1,
    OP_F32_CONST  = 4'd2,
    OP_F64_CONST  = 4'd3,
    OP_GLOBAL_GET = 4'd4,
    OP_REF_NULL   = 4'd5,
    OP_REF_FUNC   = 4'd6,
    OP_I32_ADD    = 4'd7,
    OP_I32_SUB    = 4'd8,
    OP_I32_MUL    = 4'd9,
    OP_I64_ADD    = 4'd10,
    OP_I64_SUB    = 4'd11,
    OP_I64_MUL    = 4'd12,
    OP_SET_GLOBAL = 4'd13
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_BAD_OPCODE   = 3'd1,
    ST_BAD_GLOBAL   = 3'd2,
    ST_BAD_FUNCTION = 3'd3,
    ST_EMPTY        = 3'd4,
    ST_STACK        = 3'd5
  } st_t;

  // Command that every stack cell sees in a cycle.
  typedef struct packed {
    logic push;  // every entry moves one place down, a new top comes in
    logic pop;   // every entry moves one place up, the top takes the result
  } cell_cmd_t;

endpackage

// ----- sv/cee_ram.sv -----
module cee_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/cee_cell.sv -----
module cee_cell (
  input  logic                            clk,
  input  cee_pkg::cell_cmd_t              cmd,
  input  logic [cee_pkg::VALUE_W-1:0]     from_above,
  input  logic [cee_pkg::VALUE_W-1:0]     from_below,
  output logic [cee_pkg::VALUE_W-1:0]     q
);

  logic [cee_pkg::VALUE_W-1:0] q_r;

  // A push takes the neighbor nearer the top, a pop the neighbor farther down.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      q_r <= from_above;
    end else if (cmd.pop) begin
      q_r <= from_below;
    end
  end

  assign q = q_r;

endmodule

// ----- sv/cee_mul.sv -----
module cee_mul (
  input  logic                        clk,
  input  logic                        load,
  input  logic [cee_pkg::VALUE_W-1:0] a,
  input  logic [cee_pkg::VALUE_W-1:0] b,
  output logic [cee_pkg::VALUE_W-1:0] prod
);

  localparam int HW = cee_pkg::VALUE_W / 2;

  logic [cee_pkg::VALUE_W-1:0] p_ll_r;
  logic [HW-1:0]               p_lh_r;
  logic [HW-1:0]               p_hl_r;
  logic [cee_pkg::VALUE_W-1:0] p_ll_nxt;
  logic [HW-1:0]               p_lh_nxt;
  logic [HW-1:0]               p_hl_nxt;
  logic [HW-1:0]               cross_sum;

  // Three partial products of the 32-bit halves; only the low half of the cross terms matters.
  always_comb begin
    p_ll_nxt = {{HW{1'b0}}, a[HW-1:0]} * {{HW{1'b0}}, b[HW-1:0]};
    p_lh_nxt = a[HW-1:0] * b[2*HW-1:HW];
    p_hl_nxt = a[2*HW-1:HW] * b[HW-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p_ll_r <= p_ll_nxt;
      p_lh_r <= p_lh_nxt;
      p_hl_r <= p_hl_nxt;
    end
  end

  // Fold the registered cross terms into the upper half.
  assign cross_sum = p_lh_r + p_hl_r;
  assign prod      = p_ll_r + {cross_sum, {HW{1'b0}}};

endmodule

// ----- sv/const_expr_stack_evaluator.sv -----
// An accepted request other than set_global waits in the decode stage for its table read and
// then executes; the last such request loads the result register, waiting while the output stalls.
// Throughput: one request per cycle when nothing stalls; a multiply stalls the execute stage
// because its 64-bit product is built from registered partial products of 32-bit halves.
// Reset (rst_n low, synchronous) clears the stack level, the pending error, the pipeline
// and the configuration registers; stack cells and the global table hold no reset value.
module const_expr_stack_evaluator #(
  parameter int STACK_DEPTH  = 16,
  parameter int GLOBAL_SLOTS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata: opcode[3:0], immediate[67:4], item_index[99:68], zero padding above.
  input  logic [cee_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,
  // Result channel.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata: value[63:0], status[66:64], zero padding above.
  output logic [cee_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cee_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cee_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (GLOBAL_SLOTS > 1) ? $clog2(GLOBAL_SLOTS) : 1;
  localparam int VW     = cee_pkg::VALUE_W;
  localparam int HW     = VW / 2;

  // Request fields.
  cee_pkg::op_t               in_op;
  logic [cee_pkg::IMM_W-1:0]  in_imm;
  logic [cee_pkg::IDX_W-1:0]  in_idx;
  logic                       in_acc;

  assign in_op  = cee_pkg::op_t'(in_tdata[cee_pkg::IN_OP_LSB +: cee_pkg::OP_W]);
  assign in_imm = in_tdata[cee_pkg::IN_IMM_LSB +: cee_pkg::IMM_W];
  assign in_idx = in_tdata[cee_pkg::IN_IDX_LSB +: cee_pkg::IDX_W];
  assign in_acc = in_tvalid && in_tready;

  // Configuration registers; always ready.
  logic [cee_pkg::GCOUNT_W-1:0] gcount_r;
  logic [cee_pkg::FCOUNT_W-1:0] fcount_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcount_r <= '0;
      fcount_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cee_pkg::CFG_GLOBAL_COUNT:   gcount_r <= cfg_data[cee_pkg::GCOUNT_W-1:0];
        cee_pkg::CFG_FUNCTION_COUNT: fcount_r <= cfg_data[cee_pkg::FCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Global table: set_global writes an in-range slot at accept, every accepted request reads its slot.
  logic            ram_we;
  logic [VW-1:0]   ram_rdata;

  assign ram_we = in_acc && (in_op == cee_pkg::OP_SET_GLOBAL) &&
                  (in_idx < 32'(GLOBAL_SLOTS));

  cee_ram #(
    .WIDTH (VW),
    .DEPTH (GLOBAL_SLOTS)
  ) u_globals (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_idx[ADDR_W-1:0]),
    .wdata (in_imm),
    .re    (in_acc),
    .raddr (in_idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Decode stage: holds the request while the table read completes.
  logic                       d_valid_r;
  logic                       d_valid_nxt;
  cee_pkg::op_t               d_op_r;
  logic [cee_pkg::IMM_W-1:0]  d_imm_r;
  logic [cee_pkg::IDX_W-1:0]  d_idx_r;
  logic                       d_last_r;
  logic                       ex_go;

  assign in_tready = !d_valid_r || ex_go;

  always_comb begin
    d_valid_nxt = d_valid_r;
    if (ex_go) begin
      d_valid_nxt = 1'b0;
    end
    if (in_acc && (in_op != cee_pkg::OP_SET_GLOBAL)) begin
      d_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else begin
      d_valid_r <= d_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      d_op_r   <= in_op;
      d_imm_r  <= in_imm;
      d_idx_r  <= in_idx;
      d_last_r <= in_tlast;
    end
  end

  // Stack cells, top at index 0.
  logic [VW-1:0]       cell_q [STACK_DEPTH];
  cee_pkg::cell_cmd_t  cmd;
  logic [VW-1:0]       push_data;
  logic [VW-1:0]       alu_res;
  logic [VW-1:0]       top;
  logic [VW-1:0]       second;

  assign top    = cell_q[0];
  assign second = cell_q[1];

  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    logic [VW-1:0] above;
    logic [VW-1:0] below;
    if (k == 0) begin : g_top
      assign above = push_data;
      assign below = alu_res;
    end else if (k == STACK_DEPTH - 1) begin : g_bottom
      assign above = cell_q[k-1];
      assign below = cell_q[k];
    end else begin : g_mid
      assign above = cell_q[k-1];
      assign below = cell_q[k+1];
    end
    cee_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .from_above (above),
      .from_below (below),
      .q          (cell_q[k])
    );
  end

  // Multiplier; its partial products are registered before the product is summed.
  logic            mul_phase_r;
  logic            mul_phase_nxt;
  logic            mul_need;
  logic [VW-1:0]   mul_prod;

  cee_mul u_mul (
    .clk  (clk),
    .load (mul_need && !mul_phase_r),
    .a    (second),
    .b    (top),
    .prod (mul_prod)
  );

  // Execute stage state.
  logic [LVL_W-1:0] level_r;
  logic [LVL_W-1:0] level_item;
  cee_pkg::st_t     err_r;
  cee_pkg::st_t     err_new;
  cee_pkg::st_t     err_item;
  cee_pkg::st_t     fin_status;
  logic             want_push;
  logic             do_push;
  logic             do_pop;
  logic [VW-1:0]    top_item;

  // Decode the instruction against the current stack level.
  always_comb begin
    err_new   = cee_pkg::ST_OK;
    want_push = 1'b0;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    push_data = '0;
    if (err_r == cee_pkg::ST_OK) begin
      case (d_op_r)
        cee_pkg::OP_I32_CONST, cee_pkg::OP_F32_CONST: begin
          want_push = 1'b1;
          push_data = {{HW{1'b0}}, d_imm_r[HW-1:0]};
        end
        cee_pkg::OP_I64_CONST, cee_pkg::OP_F64_CONST: begin
          want_push = 1'b1;
          push_data = d_imm_r;
        end
        cee_pkg::OP_GLOBAL_GET: begin
          if ((d_idx_r >= 32'(gcount_r)) || (d_idx_r >= 32'(GLOBAL_SLOTS))) begin
            err_new = cee_pkg::ST_BAD_GLOBAL;
          end else begin
            want_push = 1'b1;
            push_data = ram_rdata;
          end
        end
        cee_pkg::OP_REF_NULL: begin
          want_push = 1'b1;
        end
        cee_pkg::OP_REF_FUNC: begin
          if (d_idx_r >= 32'(fcount_r)) begin
            err_new = cee_pkg::ST_BAD_FUNCTION;
          end else begin
            want_push = 1'b1;
            push_data = VW'(d_idx_r) + VW'(1);
          end
        end
        cee_pkg::OP_I32_ADD, cee_pkg::OP_I32_SUB, cee_pkg::OP_I32_MUL,
        cee_pkg::OP_I64_ADD, cee_pkg::OP_I64_SUB, cee_pkg::OP_I64_MUL: begin
          if (level_r < LVL_W'(2)) begin
            err_new = cee_pkg::ST_STACK;
          end else begin
            do_pop = 1'b1;
          end
        end
        default: begin
          err_new = cee_pkg::ST_BAD_OPCODE;
        end
      endcase
      if (want_push) begin
        if (level_r >= LVL_W'(STACK_DEPTH)) begin
          err_new = cee_pkg::ST_STACK;
        end else begin
          do_push = 1'b1;
        end
      end
    end
  end

  // Arithmetic on the two top entries: second is the left operand.
  always_comb begin
    case (d_op_r)
      cee_pkg::OP_I32_ADD: alu_res = {{HW{1'b0}}, second[HW-1:0] + top[HW-1:0]};
      cee_pkg::OP_I32_SUB: alu_res = {{HW{1'b0}}, second[HW-1:0] - top[HW-1:0]};
      cee_pkg::OP_I32_MUL: alu_res = {{HW{1'b0}}, mul_prod[HW-1:0]};
      cee_pkg::OP_I64_ADD: alu_res = second + top;
      cee_pkg::OP_I64_SUB: alu_res = second - top;
      cee_pkg::OP_I64_MUL: alu_res = mul_prod;
      default:             alu_res = '0;
    endcase
  end

  // Stall a multiply while its partial products load, and a last request while the result stalls.
  assign mul_need = d_valid_r && do_pop &&
                    ((d_op_r == cee_pkg::OP_I32_MUL) || (d_op_r == cee_pkg::OP_I64_MUL));

  logic out_valid_r;
  assign ex_go = d_valid_r && !(mul_need && !mul_phase_r) &&
                 !(d_last_r && out_valid_r && !out_tready);

  always_comb begin
    mul_phase_nxt = mul_phase_r;
    if (ex_go) begin
      mul_phase_nxt = 1'b0;
    end else if (mul_need) begin
      mul_phase_nxt = 1'b1;
    end
  end

  assign cmd.push = ex_go && do_push;
  assign cmd.pop  = ex_go && do_pop;

  // Effect of this instruction and the status the last one reports.
  always_comb begin
    level_item = level_r + LVL_W'(do_push) - LVL_W'(do_pop);
    err_item   = (err_r != cee_pkg::ST_OK) ? err_r : err_new;
    if (do_push) begin
      top_item = push_data;
    end else if (do_pop) begin
      top_item = alu_res;
    end else begin
      top_item = top;
    end
    if (err_item != cee_pkg::ST_OK) begin
      fin_status = err_item;
    end else if (level_item == '0) begin
      fin_status = cee_pkg::ST_EMPTY;
    end else begin
      fin_status = cee_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      err_r       <= cee_pkg::ST_OK;
      mul_phase_r <= 1'b0;
    end else begin
      mul_phase_r <= mul_phase_nxt;
      if (ex_go) begin
        if (d_last_r) begin
          level_r <= '0;
          err_r   <= cee_pkg::ST_OK;
        end else begin
          level_r <= level_item;
          err_r   <= err_item;
        end
      end
    end
  end

  // Result register.
  logic                       out_valid_nxt;
  logic [VW-1:0]              out_value_r;
  cee_pkg::st_t               out_status_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (ex_go && d_last_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_go && d_last_r) begin
      out_status_r <= fin_status;
      out_value_r  <= (fin_status == cee_pkg::ST_OK) ? top_item : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = cee_pkg::OUT_TDATA_W'({out_status_r, out_value_r});

endmodule

// ----- sv/cee_chk.sv -----
module cee_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cee_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [cee_pkg::STATUS_W-1:0] status;
  logic [cee_pkg::VALUE_W-1:0]  value;

  assign status = out_tdata[cee_pkg::OUT_STATUS_LSB +: cee_pkg::STATUS_W];
  assign value  = out_tdata[cee_pkg::OUT_VALUE_LSB +: cee_pkg::VALUE_W];

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A failed expression reports a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status != cee_pkg::ST_OK) |-> value == '0)
    else $error("nonzero value with error status");

  // Only the defined status codes are reported.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> status <= cee_pkg::ST_STACK)
    else $error("undefined status code");

endmodule

bind const_expr_stack_evaluator cee_chk u_cee_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
